@@ hw/rtl/tibs_pkg.sv @@
`default_nettype none
package tibs_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int NUM_COLUMNS = 8;
    localparam int FRAC_BITS   = 32;

    localparam int PT_W    = $clog2(MAX_POINTS);
    localparam int COL_W   = $clog2(NUM_COLUMNS);
    localparam int TADDR_W = COL_W + PT_W;
    localparam int CMD_W   = 3;
    localparam int ORD_W   = 6;
    localparam int VAL_W   = 48;
    localparam int EXT_W   = VAL_W + 1;
    localparam int MASS_W  = 47;
    localparam int STAT_W  = 3;
    localparam int NPTS_W  = 11;
    localparam int TOL_W   = 32;
    localparam int LIM_W   = 8;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 32;

    localparam logic [CMD_W-1:0] CMD_LABEL  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GRID   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TABLE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INTERP = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SOLVE  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NO_ORDER = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NO_IVAL  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DIV0     = 3'd4;

    localparam logic [CFG_IW-1:0] CFG_POINTS = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_TOL    = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_LIMIT  = 2'd2;

    localparam logic [NPTS_W-1:0] POINTS_RST = 11'd2;
    localparam logic [TOL_W-1:0]  TOL_RST    = 32'd4295;
    localparam logic [LIM_W-1:0]  LIMIT_RST  = 8'd200;

    localparam logic [EXT_W-1:0] ONE_Q =
        {{(EXT_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [VAL_W-1:0] SAT_MAG = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct packed {
        logic              start;
        logic [EXT_W-1:0]  a;
        logic [EXT_W-1:0]  b;
        logic [EXT_W-1:0]  d;
        logic              neg;
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic [VAL_W-1:0]  q;
    } md_rsp_t;

    typedef struct packed {
        logic              label_we;
        logic              grid_we;
        logic              table_we;
        logic [COL_W-1:0]  col;
        logic [PT_W-1:0]   pt;
        logic [ORD_W-1:0]  order;
        logic [VAL_W-1:0]  data;
    } st_wr_t;

    typedef struct packed {
        logic              hit;
        logic [COL_W-1:0]  col;
    } lk_t;

    function automatic logic [EXT_W-1:0] mag49(input logic [EXT_W-1:0] v);
        mag49 = v[EXT_W-1] ? (~v + EXT_W'(1)) : v;
    endfunction

    function automatic logic [EXT_W-1:0] sx49(input logic [VAL_W-1:0] v);
        sx49 = {v[VAL_W-1], v};
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tibs_if.sv @@
`default_nettype none
interface tibs_req_if;
    import tibs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [COL_W-1:0]         column_index;
    logic [PT_W-1:0]          point_index;
    logic [ORD_W-1:0]         order_value;
    logic signed [VAL_W-1:0]  operand_value;
    logic [MASS_W-1:0]        mass;
    logic signed [VAL_W-1:0]  energy_per_number;

    modport source (output valid, cmd, column_index, point_index, order_value,
                    operand_value, mass, energy_per_number, input ready);
    modport sink (input valid, cmd, column_index, point_index, order_value,
                  operand_value, mass, energy_per_number, output ready);
endinterface

interface tibs_rsp_if;
    import tibs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  result_value;
    logic [STAT_W-1:0]        status;

    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tibs_muldiv.sv @@
`default_nettype none
module tibs_muldiv (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tibs_pkg::md_req_t req,
    output tibs_pkg::md_rsp_t      rsp
);
    import tibs_pkg::*;

    localparam int P_W   = 2 * EXT_W + 1;
    localparam int LO_W  = VAL_W - 1;
    localparam int CNT_W = $clog2(EXT_W);

    typedef enum logic [2:0] {M_IDLE, M_MUL, M_CHK, M_DIV, M_OUT} md_state_t;

    md_state_t         state_reg;
    logic [EXT_W-1:0]  a_reg;
    logic [EXT_W-1:0]  d_reg;
    logic              neg_reg;
    logic              sat_reg;
    logic [P_W-1:0]    p_reg;
    logic [EXT_W-1:0]  r_reg;
    logic [LO_W-1:0]   lo_reg;
    logic [LO_W-1:0]   q_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [EXT_W:0]    sum_w;
    logic [EXT_W:0]    rs_w;
    logic [VAL_W-1:0]  mag_w;

    assign sum_w = p_reg[P_W-1:EXT_W] + (p_reg[0] ? {1'b0, a_reg} : '0);
    assign rs_w  = {r_reg, lo_reg[LO_W-1]};
    assign mag_w = sat_reg ? SAT_MAG : {1'b0, q_reg};

    assign rsp.done = (state_reg == M_OUT);
    assign rsp.q    = neg_reg ? (~mag_w + VAL_W'(1)) : mag_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            a_reg     <= '0;
            d_reg     <= '0;
            neg_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            p_reg     <= '0;
            r_reg     <= '0;
            lo_reg    <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        a_reg     <= req.a;
                        d_reg     <= req.d;
                        neg_reg   <= req.neg;
                        p_reg     <= {{(EXT_W+1){1'b0}}, req.b};
                        cnt_reg   <= CNT_W'(EXT_W - 1);
                        state_reg <= M_MUL;
                    end
                end
                M_MUL:
                begin
                    // shift-add, one multiplier bit a cycle
                    p_reg   <= {1'b0, sum_w, p_reg[EXT_W-1:1]};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                        state_reg <= M_CHK;
                end
                M_CHK:
                begin
                    // quotient would not fit below 2^47: saturate
                    if (p_reg[P_W-2:LO_W] >= {2'b00, d_reg})
                    begin
                        sat_reg   <= 1'b1;
                        state_reg <= M_OUT;
                    end
                    else
                    begin
                        sat_reg   <= 1'b0;
                        r_reg     <= p_reg[LO_W+EXT_W-1:LO_W];
                        lo_reg    <= p_reg[LO_W-1:0];
                        q_reg     <= '0;
                        cnt_reg   <= CNT_W'(LO_W - 1);
                        state_reg <= M_DIV;
                    end
                end
                M_DIV:
                begin
                    if (rs_w >= {1'b0, d_reg})
                    begin
                        r_reg <= EXT_W'(rs_w - {1'b0, d_reg});
                        q_reg <= {q_reg[LO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= rs_w[EXT_W-1:0];
                        q_reg <= {q_reg[LO_W-2:0], 1'b0};
                    end
                    lo_reg  <= {lo_reg[LO_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                        state_reg <= M_OUT;
                end
                M_OUT:
                begin
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/tibs_store.sv @@
`default_nettype none
module tibs_store (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tibs_pkg::st_wr_t               wr,
    input  wire logic [tibs_pkg::PT_W-1:0]      grid_raddr,
    input  wire logic [tibs_pkg::TADDR_W-1:0]   table_raddr,
    input  wire logic [tibs_pkg::ORD_W-1:0]     lookup_order,
    output logic signed [tibs_pkg::VAL_W-1:0]   grid_rdata,
    output logic signed [tibs_pkg::VAL_W-1:0]   table_rdata,
    output tibs_pkg::lk_t                       lookup
);
    import tibs_pkg::*;

    logic [VAL_W-1:0] grid_mem [MAX_POINTS];
    logic [VAL_W-1:0] table_mem [NUM_COLUMNS*MAX_POINTS];
    logic [ORD_W-1:0] label_reg [NUM_COLUMNS];
    logic [NUM_COLUMNS-1:0] label_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.grid_we)
            grid_mem[wr.pt] <= wr.data;
        grid_rdata <= grid_mem[grid_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.table_we)
            table_mem[{wr.col, wr.pt}] <= wr.data;
        table_rdata <= table_mem[table_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.label_we)
            label_reg[wr.col] <= wr.order;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            label_valid_reg <= '0;
        else if (wr.label_we)
            label_valid_reg[wr.col] <= 1'b1;
    end

    // lowest numbered column with a matching label wins
    always_comb
    begin
        lookup.hit = 1'b0;
        lookup.col = '0;
        for (int c = NUM_COLUMNS - 1; c >= 0; c--)
        begin
            if (label_valid_reg[c] && (label_reg[c] == lookup_order))
            begin
                lookup.hit = 1'b1;
                lookup.col = COL_W'(c);
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/table_interpolate_bisection_solver.sv @@
`default_nettype none
// channel  dir  handshake      payload
// req      in   valid/ready    cmd, column_index, point_index, order_value,
//                              operand_value, mass, energy_per_number
// rsp      out  valid/ready    result_value, status
// cfg      in   cfg_we         cfg_index, cfg_wdata
//
// writes and unused commands are handled one request at a time.
// interpolate runs a linear grid scan at one memory read a cycle, then a
// multiply-divide in the bit-serial muldiv.
// solve runs bisection steps, then a final divide; the shared muldiv sets
// the pace.
// reset clears control state and marks all order labels invalid.
// req is not ready while a request is in work; a pending result holds in the
// output register until rsp.ready.
module table_interpolate_bisection_solver (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    tibs_req_if.sink                           req,
    tibs_rsp_if.source                         rsp,
    input  wire logic                          cfg_we,
    input  wire logic [tibs_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [tibs_pkg::CFG_DW-1:0]   cfg_wdata
);
    import tibs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_INTERP_END, ST_SOLVE, ST_SV_G0, ST_SV_GN, ST_SV_CHECK,
        ST_SV_FL, ST_SV_FM, ST_SV_FIN, ST_SV_DIV, ST_E_START, ST_E_K2,
        ST_E_K1, ST_E_RATIO, ST_E_TERM, ST_I_START, ST_I_G0, ST_I_GN,
        ST_I_SCAN, ST_I_TA, ST_I_TB, ST_I_MD, ST_DONE
    } state_t;

    state_t                   state_reg;
    state_t                   iret_reg;
    state_t                   eret_reg;

    logic [NPTS_W-1:0]        points_reg;
    logic [TOL_W-1:0]         tol_reg;
    logic [LIM_W-1:0]         limit_reg;

    logic [MASS_W-1:0]        mass_reg;
    logic [VAL_W-1:0]         energy_reg;
    logic [VAL_W-1:0]         low_reg;
    logic [VAL_W-1:0]         high_reg;
    logic [LIM_W-1:0]         iter_reg;
    logic [VAL_W-1:0]         ez_reg;
    logic                     fl_neg_reg;
    logic                     fl_zero_reg;
    logic [EXT_W-1:0]         k2_reg;
    logic [VAL_W-1:0]         ratio_reg;
    logic [EXT_W-1:0]         f_reg;

    logic [ORD_W-1:0]         iorder_reg;
    logic signed [VAL_W-1:0]  ix_reg;
    logic [COL_W-1:0]         icol_reg;
    logic [PT_W-1:0]          iidx_reg;
    logic signed [VAL_W-1:0]  x0_reg;
    logic signed [VAL_W-1:0]  x1_reg;
    logic [VAL_W-1:0]         y0_reg;
    logic [STAT_W-1:0]        ist_reg;
    logic [EXT_W-1:0]         ival_reg;

    logic [VAL_W-1:0]         res_reg;
    logic [STAT_W-1:0]        stat_reg;
    logic                     out_valid_reg;
    logic [VAL_W-1:0]         out_res_reg;
    logic [STAT_W-1:0]        out_stat_reg;

    md_req_t                  md_req_reg;
    md_rsp_t                  md_rsp;
    st_wr_t                   st_wr;
    lk_t                      lookup;
    logic signed [VAL_W-1:0]  grid_rdata;
    logic signed [VAL_W-1:0]  table_rdata;
    logic [PT_W-1:0]          grid_raddr;
    logic [TADDR_W-1:0]       table_raddr;

    logic [NPTS_W-1:0]        npts_w;
    logic [PT_W-1:0]          last_idx_w;
    logic [EXT_W-1:0]         mid_sum_w;
    logic [VAL_W-1:0]         mid_w;
    logic signed [EXT_W-1:0]  span_w;
    logic                     span_gt_w;
    logic [EXT_W-1:0]         dy_w;
    logic [EXT_W-1:0]         dx_w;
    logic [EXT_W-1:0]         dxx_w;
    logic                     req_take;

    tibs_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req_reg),
        .rsp   (md_rsp)
    );

    tibs_store u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (st_wr),
        .grid_raddr   (grid_raddr),
        .table_raddr  (table_raddr),
        .lookup_order (iorder_reg),
        .grid_rdata   (grid_rdata),
        .table_rdata  (table_rdata),
        .lookup       (lookup)
    );

    assign req.ready        = (state_reg == ST_IDLE);
    assign req_take         = req.valid && (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_res_reg;
    assign rsp.status       = out_stat_reg;

    assign st_wr.label_we = req_take && (req.cmd == CMD_LABEL);
    assign st_wr.grid_we  = req_take && (req.cmd == CMD_GRID);
    assign st_wr.table_we = req_take && (req.cmd == CMD_TABLE);
    assign st_wr.col      = req.column_index;
    assign st_wr.pt       = req.point_index;
    assign st_wr.order    = req.order_value;
    assign st_wr.data     = req.operand_value;

    assign npts_w = (points_reg < NPTS_W'(2)) ? NPTS_W'(2) :
                    (points_reg > NPTS_W'(MAX_POINTS)) ? NPTS_W'(MAX_POINTS) :
                    points_reg;
    assign last_idx_w = PT_W'(npts_w - NPTS_W'(1));

    assign mid_sum_w = sx49(low_reg) + sx49(high_reg);
    assign mid_w     = mid_sum_w[EXT_W-1:1];
    assign span_w    = $signed(sx49(high_reg) - sx49(low_reg));
    assign span_gt_w = span_w > $signed({{(EXT_W-TOL_W){1'b0}}, tol_reg});

    assign dy_w  = sx49(table_rdata) - sx49(y0_reg);
    assign dx_w  = sx49(ix_reg) - sx49(x0_reg);
    assign dxx_w = sx49(x1_reg) - sx49(x0_reg);

    always_comb
    begin
        unique case (state_reg)
            ST_I_G0, ST_SV_G0: grid_raddr = last_idx_w;
            ST_I_GN:           grid_raddr = PT_W'(1);
            ST_I_SCAN:         grid_raddr = iidx_reg + PT_W'(2);
            default:           grid_raddr = '0;
        endcase
        if (state_reg == ST_I_TA)
            table_raddr = {icol_reg, iidx_reg + PT_W'(1)};
        else
            table_raddr = {icol_reg, iidx_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg <= POINTS_RST;
            tol_reg    <= TOL_RST;
            limit_reg  <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POINTS: points_reg <= cfg_wdata[NPTS_W-1:0];
                CFG_TOL:    tol_reg    <= cfg_wdata[TOL_W-1:0];
                CFG_LIMIT:  limit_reg  <= cfg_wdata[LIM_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iret_reg      <= ST_IDLE;
            eret_reg      <= ST_IDLE;
            mass_reg      <= '0;
            energy_reg    <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            iter_reg      <= '0;
            ez_reg        <= '0;
            fl_neg_reg    <= 1'b0;
            fl_zero_reg   <= 1'b0;
            k2_reg        <= '0;
            ratio_reg     <= '0;
            f_reg         <= '0;
            iorder_reg    <= '0;
            ix_reg        <= '0;
            icol_reg      <= '0;
            iidx_reg      <= '0;
            x0_reg        <= '0;
            x1_reg        <= '0;
            y0_reg        <= '0;
            ist_reg       <= STAT_OK;
            ival_reg      <= '0;
            res_reg       <= '0;
            stat_reg      <= STAT_OK;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
            out_stat_reg  <= STAT_OK;
            md_req_reg    <= '0;
        end
        else
        begin
            // start is a one-cycle pulse, raised only from states that then wait
            if (md_req_reg.start)
                md_req_reg.start <= 1'b0;
            if (out_valid_reg && rsp.ready && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        mass_reg   <= req.mass;
                        energy_reg <= req.energy_per_number;
                        res_reg    <= '0;
                        stat_reg   <= STAT_OK;
                        unique case (req.cmd)
                            CMD_INTERP:
                            begin
                                iorder_reg <= req.order_value;
                                ix_reg     <= req.operand_value;
                                iret_reg   <= ST_INTERP_END;
                                state_reg  <= ST_I_START;
                            end
                            CMD_SOLVE: state_reg <= ST_SOLVE;
                            default:   state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_INTERP_END:
                begin
                    res_reg   <= (ist_reg == STAT_OK) ? ival_reg[VAL_W-1:0] : '0;
                    stat_reg  <= ist_reg;
                    state_reg <= ST_DONE;
                end
                ST_SOLVE:
                begin
                    state_reg <= ST_SV_G0;
                end
                ST_SV_G0:
                begin
                    low_reg   <= grid_rdata;
                    state_reg <= ST_SV_GN;
                end
                ST_SV_GN:
                begin
                    high_reg  <= grid_rdata;
                    iter_reg  <= '0;
                    state_reg <= ST_SV_CHECK;
                end
                ST_SV_CHECK:
                begin
                    if (span_gt_w && (iter_reg < limit_reg))
                    begin
                        ez_reg    <= low_reg;
                        eret_reg  <= ST_SV_FL;
                        state_reg <= ST_E_START;
                    end
                    else
                        state_reg <= ST_SV_FIN;
                end
                ST_SV_FL:
                begin
                    fl_neg_reg  <= f_reg[EXT_W-1];
                    fl_zero_reg <= (f_reg == '0);
                    ez_reg      <= mid_w;
                    eret_reg    <= ST_SV_FM;
                    state_reg   <= ST_E_START;
                end
                ST_SV_FM:
                begin
                    if (fl_zero_reg || (f_reg == '0) || (fl_neg_reg != f_reg[EXT_W-1]))
                        high_reg <= mid_w;
                    else
                        low_reg <= mid_w;
                    iter_reg  <= iter_reg + LIM_W'(1);
                    state_reg <= ST_SV_CHECK;
                end
                ST_SV_FIN:
                begin
                    if (mid_w == '0)
                    begin
                        stat_reg  <= STAT_DIV0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        md_req_reg.start <= 1'b1;
                        md_req_reg.a     <= {2'b00, mass_reg};
                        md_req_reg.b     <= ONE_Q;
                        md_req_reg.d     <= mag49(sx49(mid_w));
                        md_req_reg.neg   <= mid_w[VAL_W-1];
                        state_reg        <= ST_SV_DIV;
                    end
                end
                ST_SV_DIV:
                begin
                    if (md_rsp.done)
                    begin
                        res_reg   <= md_rsp.q;
                        state_reg <= ST_DONE;
                    end
                end
                ST_E_START:
                begin
                    iorder_reg <= ORD_W'(2);
                    ix_reg     <= ez_reg;
                    iret_reg   <= ST_E_K2;
                    state_reg  <= ST_I_START;
                end
                ST_E_K2:
                begin
                    if (ist_reg != STAT_OK)
                    begin
                        stat_reg  <= ist_reg;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        k2_reg     <= ival_reg;
                        iorder_reg <= ORD_W'(1);
                        ix_reg     <= ez_reg;
                        iret_reg   <= ST_E_K1;
                        state_reg  <= ST_I_START;
                    end
                end
                ST_E_K1:
                begin
                    if (ist_reg != STAT_OK)
                    begin
                        stat_reg  <= ist_reg;
                        state_reg <= ST_DONE;
                    end
                    else if (ival_reg == '0)
                    begin
                        stat_reg  <= STAT_DIV0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        md_req_reg.start <= 1'b1;
                        md_req_reg.a     <= mag49(k2_reg);
                        md_req_reg.b     <= ONE_Q;
                        md_req_reg.d     <= mag49(ival_reg);
                        md_req_reg.neg   <= k2_reg[EXT_W-1] ^ ival_reg[EXT_W-1];
                        state_reg        <= ST_E_RATIO;
                    end
                end
                ST_E_RATIO:
                begin
                    if (md_rsp.done)
                    begin
                        ratio_reg <= md_rsp.q;
                        if (mass_reg == '0)
                        begin
                            stat_reg  <= STAT_DIV0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            md_req_reg.start <= 1'b1;
                            md_req_reg.a     <= mag49(sx49(ez_reg));
                            md_req_reg.b     <= mag49(sx49(energy_reg));
                            md_req_reg.d     <= {2'b00, mass_reg};
                            md_req_reg.neg   <= ez_reg[VAL_W-1] ^ energy_reg[VAL_W-1];
                            state_reg        <= ST_E_TERM;
                        end
                    end
                end
                ST_E_TERM:
                begin
                    if (md_rsp.done)
                    begin
                        f_reg     <= sx49(ratio_reg) - sx49(md_rsp.q);
                        state_reg <= eret_reg;
                    end
                end
                ST_I_START:
                begin
                    if (!lookup.hit)
                    begin
                        ist_reg   <= STAT_NO_ORDER;
                        state_reg <= iret_reg;
                    end
                    else
                    begin
                        icol_reg  <= lookup.col;
                        state_reg <= ST_I_G0;
                    end
                end
                ST_I_G0:
                begin
                    x0_reg    <= grid_rdata;
                    state_reg <= ST_I_GN;
                end
                ST_I_GN:
                begin
                    if ((ix_reg < x0_reg) || (ix_reg > grid_rdata))
                    begin
                        ist_reg   <= STAT_RANGE;
                        state_reg <= iret_reg;
                    end
                    else
                    begin
                        iidx_reg  <= '0;
                        state_reg <= ST_I_SCAN;
                    end
                end
                ST_I_SCAN:
                begin
                    // grid read for the next point is already under way
                    if ((ix_reg >= x0_reg) && (ix_reg <= grid_rdata))
                    begin
                        x1_reg    <= grid_rdata;
                        state_reg <= ST_I_TA;
                    end
                    else if (iidx_reg == (last_idx_w - PT_W'(1)))
                    begin
                        ist_reg   <= STAT_NO_IVAL;
                        state_reg <= iret_reg;
                    end
                    else
                    begin
                        x0_reg   <= grid_rdata;
                        iidx_reg <= iidx_reg + PT_W'(1);
                    end
                end
                ST_I_TA:
                begin
                    y0_reg    <= table_rdata;
                    state_reg <= ST_I_TB;
                end
                ST_I_TB:
                begin
                    if (x1_reg == x0_reg)
                    begin
                        ist_reg   <= STAT_DIV0;
                        state_reg <= iret_reg;
                    end
                    else
                    begin
                        md_req_reg.start <= 1'b1;
                        md_req_reg.a     <= mag49(dy_w);
                        md_req_reg.b     <= dx_w;
                        md_req_reg.d     <= dxx_w;
                        md_req_reg.neg   <= dy_w[EXT_W-1];
                        state_reg        <= ST_I_MD;
                    end
                end
                ST_I_MD:
                begin
                    if (md_rsp.done)
                    begin
                        ival_reg  <= sx49(y0_reg) + sx49(md_rsp.q);
                        ist_reg   <= STAT_OK;
                        state_reg <= iret_reg;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_res_reg   <= res_reg;
                        out_stat_reg  <= stat_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("accepted request left the sequencer idle");

    a_md_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> ((state_reg == ST_I_MD) || (state_reg == ST_E_RATIO) ||
                         (state_reg == ST_E_TERM) || (state_reg == ST_SV_DIV)))
        else $error("muldiv finished with no sequencer state waiting");

    a_iter_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SV_FM) |-> (iter_reg < limit_reg))
        else $error("bisection step beyond iteration limit");

endmodule
`default_nettype wire
